// ===== design/udec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, status codes, constants and helper functions of the decoder.
// ----------------------------------------------------------------------------
package udec_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SURROGATE = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [31:0] REPLACEMENT    = 32'h0000_FFFD;
  localparam logic [31:0] MAX_LEGAL      = 32'h0010_FFFF;
  localparam logic [31:0] SURROGATE_LOW  = 32'h0000_D800;
  localparam logic [31:0] SURROGATE_HIGH = 32'h0000_DFFF;

  localparam logic STRICT_RESET = 1'b1;

  typedef struct packed {
    logic [31:0] acc;
    logic [7:0]  lead;
    logic [2:0]  rem;
    logic [2:0]  len;
    logic        illegal;
    logic        halted;
  } state_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic [2:0]  status;
    logic        text_done;
  } result_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'hC0) len = 3'd1;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else len = 3'd6;
    return len;
  endfunction

  function automatic logic [31:0] length_offset(input logic [2:0] len);
    logic [31:0] off;
    unique case (len)
      3'd2:    off = 32'h0000_3080;
      3'd3:    off = 32'h000E_2080;
      3'd4:    off = 32'h03C8_2080;
      3'd5:    off = 32'hFA08_2080;
      3'd6:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

  function automatic logic second_byte_bad(input logic [7:0] lead, input logic [7:0] b);
    logic bad;
    if (b > 8'hBF) begin
      bad = 1'b1;
    end else begin
      case (lead)
        8'hE0:   bad = (b < 8'hA0);
        8'hED:   bad = (b > 8'h9F);
        8'hF0:   bad = (b < 8'h90);
        8'hF4:   bad = (b > 8'h8F);
        default: bad = (b < 8'h80);
      endcase
    end
    return bad;
  endfunction

endpackage
`default_nettype wire

// ===== design/udec_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder step logic
// Combinational next-state and result logic for one byte of the text.
// ----------------------------------------------------------------------------
module udec_step (
  input  wire udec_pkg::state_t  state,
  input  wire logic [7:0]        text_byte,
  input  wire logic              end_of_text,
  input  wire logic              strict_mode,
  output udec_pkg::state_t       state_next,
  output logic                   res_valid,
  output udec_pkg::result_t      res
);
  import udec_pkg::*;

  logic [31:0] acc_n;
  logic [7:0]  lead_n;
  logic [2:0]  rem_n;
  logic [2:0]  len_n;
  logic        ill_n;
  logic [2:0]  lead_len;
  logic [2:0]  pos;
  logic        cont_bad;
  logic [31:0] ch;
  logic [31:0] fin_code;
  logic [2:0]  fin_status;

  assign lead_len = lead_length(text_byte);
  assign pos      = state.len - state.rem;
  assign cont_bad = (pos == 3'd1) ? second_byte_bad(state.lead, text_byte)
                                  : (text_byte < 8'h80 || text_byte > 8'hBF);

  always_comb begin
    if (state.rem == 3'd0) begin
      lead_n = text_byte;
      len_n  = lead_len;
      rem_n  = lead_len - 3'd1;
      acc_n  = {24'd0, text_byte};
      ill_n  = (lead_len > 3'd4) || (text_byte >= 8'h80 && text_byte < 8'hC2) ||
               (text_byte > 8'hF4);
    end else begin
      lead_n = state.lead;
      len_n  = state.len;
      rem_n  = state.rem - 3'd1;
      acc_n  = {state.acc[25:0], 6'd0} + {24'd0, text_byte};
      ill_n  = state.illegal | cont_bad;
    end
  end

  assign ch = acc_n - length_offset(len_n);

  always_comb begin
    if (strict_mode && ill_n) begin
      fin_code   = 32'd0;
      fin_status = ST_ILLEGAL;
    end else if (ch <= MAX_LEGAL) begin
      if (ch >= SURROGATE_LOW && ch <= SURROGATE_HIGH) begin
        if (strict_mode) begin
          fin_code   = 32'd0;
          fin_status = ST_ILLEGAL;
        end else begin
          fin_code   = REPLACEMENT;
          fin_status = ST_SURROGATE;
        end
      end else begin
        fin_code   = ch;
        fin_status = ST_OK;
      end
    end else begin
      fin_code   = REPLACEMENT;
      fin_status = ST_RANGE;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res        = '0;
    if (state.halted) begin
      if (end_of_text) begin
        state_next = '0;
      end
    end else if (rem_n != 3'd0) begin
      if (end_of_text) begin
        state_next    = '0;
        res_valid     = 1'b1;
        res.status    = ST_TRUNC;
        res.text_done = 1'b1;
      end else begin
        state_next.acc     = acc_n;
        state_next.lead    = lead_n;
        state_next.rem     = rem_n;
        state_next.len     = len_n;
        state_next.illegal = ill_n;
      end
    end else begin
      state_next        = '0;
      state_next.halted = (fin_status == ST_ILLEGAL) && !end_of_text;
      res_valid         = 1'b1;
      res.code_point    = fin_code;
      res.status        = fin_status;
      res.text_done     = end_of_text;
    end
  end

endmodule
`default_nettype wire

// ===== design/udec_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one decoded result until the receiver completes the transaction.
// ----------------------------------------------------------------------------
module udec_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire udec_pkg::result_t load_data,
  output logic                   free,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output udec_pkg::result_t      result_data
);
  import udec_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      result_data <= load_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/utf8_to_utf32_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 to UTF-32 decoder core
// Decodes a byte stream with end-of-text marks into code points with status.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while text_ready is high and
// gives at most one result per byte. Each byte passes an input register,
// then the decode logic (one shift-add, one offset subtraction and range
// compares) updates the sequence state and loads the result register in
// the same cycle. A result that waits on the output holds the byte behind
// it, so the sustained rate is one byte per cycle whenever the receiver
// keeps result_ready high. The strict_mode register resets to 1 and may be
// written only while no transaction is in flight.
module utf8_to_utf32_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        strict_mode,
  input  wire logic        text_valid,
  output logic             text_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [31:0]      code_point,
  output logic [2:0]       status,
  output logic             text_done
);
  import udec_pkg::*;

  logic       strict;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eot;
  state_t     state;
  state_t     state_next;
  logic       step_res_valid;
  result_t    step_res;
  result_t    out_data;
  logic       out_free;
  logic       step_en;

  assign cfg_ready  = 1'b1;
  assign step_en    = in_valid && out_free;
  assign text_ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict <= STRICT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      strict <= strict_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_ready) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_ready && text_valid) begin
      in_byte <= text_byte;
      in_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step_en) begin
      state <= state_next;
    end
  end

  udec_step u_step (
    .state       (state),
    .text_byte   (in_byte),
    .end_of_text (in_eot),
    .strict_mode (strict),
    .state_next  (state_next),
    .res_valid   (step_res_valid),
    .res         (step_res)
  );

  udec_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step_en && step_res_valid),
    .load_data    (step_res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (out_data)
  );

  assign code_point = out_data.code_point;
  assign status     = out_data.status;
  assign text_done  = out_data.text_done;

  // A halted decoder never holds an open sequence.
  assert property (@(posedge clk) disable iff (rst) state.halted |-> state.rem == 3'd0)
    else $error("halted with an open sequence");

  // The remaining count of an open sequence stays below its length.
  assert property (@(posedge clk) disable iff (rst) state.rem != 3'd0 |-> state.rem < state.len)
    else $error("remaining byte count exceeds sequence length");

  // The halt is entered only together with a fresh illegal result.
  assert property (@(posedge clk) disable iff (rst)
    $rose(state.halted) |-> result_valid && status == ST_ILLEGAL && !text_done)
    else $error("halt without an illegal result");

  // A truncated result always closes the text and carries no code point.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_TRUNC |-> text_done && code_point == 32'd0)
    else $error("malformed truncation result");

endmodule
`default_nettype wire
